/* hdl/cbp_pkg.sv */
// Package for the complex ball projection: word types, action codes,
// pipeline widths and the side-band record that travels with each word.
// No dependencies.
`timescale 1ns / 1ps

package cbp_pkg;

	localparam int MAG_W      = 33;
	localparam int SQ_W       = 66;
	localparam int ROOT_W     = 33;
	localparam int ROOT_STEPS = 33;
	localparam int RAD_W      = 31;
	localparam int PROD_W     = 64;
	localparam int NUM_W      = 66;
	localparam int DEN_W      = 34;
	localparam int QUOT_STEPS = 31;

	typedef enum logic [1:0] {
		ACT_PASS    = 2'd0,
		ACT_REPLACE = 2'd1,
		ACT_CLAMP   = 2'd2
	} action_t;

	typedef struct packed {
		logic signed [31:0] model_re;
		logic signed [31:0] model_im;
		logic signed [31:0] target_re;
		logic signed [31:0] target_im;
		logic               target_valid;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] result_re;
		logic signed [31:0] result_im;
		logic [1:0]         action;
	} out_word_t;

	typedef struct packed {
		action_t            action;
		logic signed [31:0] base_re;
		logic signed [31:0] base_im;
		logic               sgn_re;
		logic               sgn_im;
		logic [MAG_W-1:0]   mag_re;
		logic [MAG_W-1:0]   mag_im;
	} side_t;

endpackage

/* hdl/cbp_sqrt.sv */
// Pipelined integer square root, one result bit per stage.
// Depends on cbp_pkg.
`timescale 1ns / 1ps

module cbp_sqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic [cbp_pkg::SQ_W-1:0]   sq,
	input  cbp_pkg::side_t             in_side,
	output logic                       out_valid,
	output logic [cbp_pkg::ROOT_W-1:0] root,
	output cbp_pkg::side_t             out_side
);
	import cbp_pkg::*;

	localparam int RW = SQ_W + 1;

	logic [RW-1:0] rem_s  [0:ROOT_STEPS];
	logic [RW-1:0] res_s  [0:ROOT_STEPS];
	side_t         side_s [0:ROOT_STEPS];
	logic          vld_s  [0:ROOT_STEPS];

	assign rem_s[0]  = {1'b0, sq};
	assign res_s[0]  = '0;
	assign side_s[0] = in_side;
	assign vld_s[0]  = in_valid;

	for (genvar i = 0; i < ROOT_STEPS; i++) begin : g_step
		localparam int SH = 2 * (ROOT_STEPS - 1 - i);
		logic [RW-1:0] bit_w;
		logic [RW-1:0] try_w;

		assign bit_w = RW'(1) << SH;
		assign try_w = res_s[i] + bit_w;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[i+1] <= side_s[i];
				if (rem_s[i] >= try_w) begin
					rem_s[i+1] <= rem_s[i] - try_w;
					res_s[i+1] <= (res_s[i] >> 1) + bit_w;
				end else begin
					rem_s[i+1] <= rem_s[i];
					res_s[i+1] <= res_s[i] >> 1;
				end
			end
		end
	end

	assign out_valid = vld_s[ROOT_STEPS];
	assign root      = res_s[ROOT_STEPS][ROOT_W-1:0];
	assign out_side  = side_s[ROOT_STEPS];

endmodule

/* hdl/cbp_div.sv */
// Pipelined restoring divider for both offset lanes, one quotient bit per stage.
// Depends on cbp_pkg.
`timescale 1ns / 1ps

module cbp_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic [cbp_pkg::NUM_W-1:0] num_re,
	input  logic [cbp_pkg::NUM_W-1:0] num_im,
	input  logic [cbp_pkg::DEN_W-1:0] den,
	input  cbp_pkg::side_t            in_side,
	output logic                      out_valid,
	output logic [cbp_pkg::RAD_W-1:0] q_re,
	output logic [cbp_pkg::RAD_W-1:0] q_im,
	output cbp_pkg::side_t            out_side
);
	import cbp_pkg::*;

	logic [NUM_W-1:0] rre_s  [0:QUOT_STEPS];
	logic [NUM_W-1:0] rim_s  [0:QUOT_STEPS];
	logic [RAD_W-1:0] qre_s  [0:QUOT_STEPS];
	logic [RAD_W-1:0] qim_s  [0:QUOT_STEPS];
	logic [DEN_W-1:0] den_s  [0:QUOT_STEPS];
	side_t            side_s [0:QUOT_STEPS];
	logic             vld_s  [0:QUOT_STEPS];

	assign rre_s[0]  = num_re;
	assign rim_s[0]  = num_im;
	assign qre_s[0]  = '0;
	assign qim_s[0]  = '0;
	assign den_s[0]  = den;
	assign side_s[0] = in_side;
	assign vld_s[0]  = in_valid;

	for (genvar j = 0; j < QUOT_STEPS; j++) begin : g_step
		localparam int SH = QUOT_STEPS - 1 - j;
		logic [NUM_W-1:0] dsh_w;
		logic [RAD_W-1:0] qbit_w;

		assign dsh_w  = NUM_W'(den_s[j]) << SH;
		assign qbit_w = RAD_W'(1) << SH;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else if (en) begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[j+1] <= side_s[j];
				den_s[j+1]  <= den_s[j];
				if (rre_s[j] >= dsh_w) begin
					rre_s[j+1] <= rre_s[j] - dsh_w;
					qre_s[j+1] <= qre_s[j] | qbit_w;
				end else begin
					rre_s[j+1] <= rre_s[j];
					qre_s[j+1] <= qre_s[j];
				end
				if (rim_s[j] >= dsh_w) begin
					rim_s[j+1] <= rim_s[j] - dsh_w;
					qim_s[j+1] <= qim_s[j] | qbit_w;
				end else begin
					rim_s[j+1] <= rim_s[j];
					qim_s[j+1] <= qim_s[j];
				end
			end
		end
	end

	assign out_valid = vld_s[QUOT_STEPS];
	assign q_re      = qre_s[QUOT_STEPS];
	assign q_im      = qim_s[QUOT_STEPS];
	assign out_side  = side_s[QUOT_STEPS];

endmodule

/* hdl/complex_ball_projection.sv */
// Complex ball projection top level: difference, squares, disc test, square
// root, scaling divide and saturating output. Depends on cbp_pkg, cbp_sqrt, cbp_div.
// Throughput is one word per cycle while the output is not stalled.
// The whole pipeline advances together; it stalls only while the output word waits.
// Depth is set by the 33-stage square root and the 31-stage divider.
// Reset clears all valid bits and sets radius to zero.
`timescale 1ns / 1ps

module complex_ball_projection (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [cbp_pkg::RAD_W-1:0]     wr_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  cbp_pkg::in_word_t             in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output cbp_pkg::out_word_t            out_data
);
	import cbp_pkg::*;

	logic [RAD_W-1:0]   radius_q;
	logic [2*RAD_W-1:0] rr_q;
	logic               en;

	logic signed [MAG_W-1:0] dr_w, di_w;
	side_t                   side_w;

	logic             v_s1, v_s2, v_s3, v_s4, v_s5;
	side_t            side_s1, side_s2, side_s3, side_s4, side_s5;
	side_t            side_a_w;
	logic             tv_s1, tv_s2;
	logic [SQ_W-1:0]  sqr_s2, sqi_s2, sum_s3;
	logic [SQ_W-1:0]  sum_w;
	action_t          act_w;

	logic             v_r;
	logic [ROOT_W-1:0] root_r;
	side_t            side_r;
	logic [PROD_W-1:0] pre_s4, pim_s4;
	logic [ROOT_W-1:0] root_s4;
	logic [NUM_W-1:0] nre_s5, nim_s5;
	logic [DEN_W-1:0] den_s5;

	logic             v_d;
	logic [RAD_W-1:0] q_re, q_im;
	side_t            side_d;
	logic signed [33:0] sre_w, sim_w;
	logic signed [31:0] satre_w, satim_w;
	out_word_t        out_w;
	out_word_t        out_q;
	logic             out_valid_q;

	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= '0;
			rr_q     <= '0;
		end else if (wr_en) begin
			radius_q <= wr_data;
			rr_q     <= (2*RAD_W)'(wr_data) * (2*RAD_W)'(wr_data);
		end
	end

	assign dr_w = {in_data.model_re[31], in_data.model_re}
		- {in_data.target_re[31], in_data.target_re};
	assign di_w = {in_data.model_im[31], in_data.model_im}
		- {in_data.target_im[31], in_data.target_im};

	always_comb begin
		side_w         = '0;
		side_w.action  = ACT_PASS;
		side_w.base_re = in_data.target_valid ? in_data.target_re : in_data.model_re;
		side_w.base_im = in_data.target_valid ? in_data.target_im : in_data.model_im;
		side_w.sgn_re  = dr_w[MAG_W-1];
		side_w.sgn_im  = di_w[MAG_W-1];
		side_w.mag_re  = dr_w[MAG_W-1] ? MAG_W'(-dr_w) : MAG_W'(dr_w);
		side_w.mag_im  = di_w[MAG_W-1] ? MAG_W'(-di_w) : MAG_W'(di_w);
	end

	assign sum_w = sqr_s2 + sqi_s2;

	always_comb begin
		if (!tv_s2) begin
			act_w = ACT_PASS;
		end else if (radius_q == '0 || sum_w < SQ_W'(rr_q)) begin
			act_w = ACT_REPLACE;
		end else begin
			act_w = ACT_CLAMP;
		end
	end

	always_comb begin
		side_a_w        = side_s2;
		side_a_w.action = act_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_r;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_w;
			tv_s1   <= in_data.target_valid;

			side_s2 <= side_s1;
			tv_s2   <= tv_s1;
			sqr_s2  <= SQ_W'(side_s1.mag_re) * SQ_W'(side_s1.mag_re);
			sqi_s2  <= SQ_W'(side_s1.mag_im) * SQ_W'(side_s1.mag_im);

			side_s3 <= side_a_w;
			sum_s3  <= sum_w;

			side_s4 <= side_r;
			root_s4 <= root_r;
			pre_s4  <= PROD_W'(radius_q) * PROD_W'(side_r.mag_re);
			pim_s4  <= PROD_W'(radius_q) * PROD_W'(side_r.mag_im);

			side_s5 <= side_s4;
			nre_s5  <= NUM_W'({pre_s4, 1'b0}) + NUM_W'(root_s4);
			nim_s5  <= NUM_W'({pim_s4, 1'b0}) + NUM_W'(root_s4);
			den_s5  <= {root_s4, 1'b0};
		end
	end

	cbp_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.sq        (sum_s3),
		.in_side   (side_s3),
		.out_valid (v_r),
		.root      (root_r),
		.out_side  (side_r)
	);

	cbp_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s5),
		.num_re    (nre_s5),
		.num_im    (nim_s5),
		.den       (den_s5),
		.in_side   (side_s5),
		.out_valid (v_d),
		.q_re      (q_re),
		.q_im      (q_im),
		.out_side  (side_d)
	);

	assign sre_w = 34'(side_d.base_re)
		+ (side_d.sgn_re ? -$signed({3'b000, q_re}) : $signed({3'b000, q_re}));
	assign sim_w = 34'(side_d.base_im)
		+ (side_d.sgn_im ? -$signed({3'b000, q_im}) : $signed({3'b000, q_im}));

	always_comb begin
		if (sre_w > 34'sh0_7FFF_FFFF) begin
			satre_w = 32'sh7FFF_FFFF;
		end else if (sre_w < -34'sh0_8000_0000) begin
			satre_w = 32'sh8000_0000;
		end else begin
			satre_w = sre_w[31:0];
		end
		if (sim_w > 34'sh0_7FFF_FFFF) begin
			satim_w = 32'sh7FFF_FFFF;
		end else if (sim_w < -34'sh0_8000_0000) begin
			satim_w = 32'sh8000_0000;
		end else begin
			satim_w = sim_w[31:0];
		end
	end

	always_comb begin
		out_w.action = side_d.action;
		if (side_d.action == ACT_CLAMP) begin
			out_w.result_re = satre_w;
			out_w.result_im = satim_w;
		end else begin
			out_w.result_re = side_d.base_re;
			out_w.result_im = side_d.base_im;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= v_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q <= out_w;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

/* test/complex_ball_projection_test.sv */
// Testbench for complex_ball_projection: directed and random input words with
// a behavioral predictor, bursty sender and stalling receiver.
// Depends on cbp_pkg and the complex_ball_projection RTL.
`timescale 1ns / 1ps

module complex_ball_projection_test;
	import cbp_pkg::*;

	localparam int LATENCY = 70;

	logic               clk;
	logic               arst_n;
	logic               wr_en;
	logic [RAD_W-1:0]   wr_data;
	logic               in_valid;
	logic               in_ready;
	in_word_t           in_data;
	logic               out_valid;
	logic               out_ready;
	out_word_t          out_data;

	out_word_t          expected_q[$];
	logic [RAD_W-1:0]   radius_reg;
	int                 n_errors;
	int                 burst_left;

	complex_ball_projection u_dut (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_en), .wr_data(wr_data),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always begin
		clk = 1'b1; #6;
		clk = 1'b0; #6;
	end

	function automatic logic signed [31:0] sat32(logic signed [65:0] v);
		if (v > 66'sd2147483647) return 32'sh7fffffff;
		if (v < -66'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic [32:0] root_floor(logic [65:0] s);
		logic [32:0] m;
		logic [32:0] c;
		m = '0;
		for (int b = 32; b >= 0; b--) begin
			c = m | (33'd1 << b);
			if ({66'd0, c} * {66'd0, c} <= {66'd0, s}) m = c;
		end
		return m;
	endfunction

	function automatic logic signed [65:0] offset(logic signed [32:0] d, logic [32:0] m);
		logic [32:0]  mag;
		logic [65:0]  p;
		logic [65:0]  q;
		mag = d < 0 ? -d : d;
		p = {35'd0, radius_reg} * {33'd0, mag};
		q = (2 * p + m) / (2 * {33'd0, m});
		return d < 0 ? -$signed(q) : $signed(q);
	endfunction

	function automatic out_word_t project(in_word_t w);
		out_word_t           r;
		logic signed [32:0]  dr;
		logic signed [32:0]  di;
		logic [65:0]         s;
		logic [32:0]         m;
		if (!w.target_valid) begin
			r.result_re = w.model_re;
			r.result_im = w.model_im;
			r.action = ACT_PASS;
			return r;
		end
		dr = 33'(w.model_re) - 33'(w.target_re);
		di = 33'(w.model_im) - 33'(w.target_im);
		s = $unsigned(66'(dr) * 66'(dr)) + $unsigned(66'(di) * 66'(di));
		if (radius_reg == 0 || s < {35'd0, radius_reg} * {35'd0, radius_reg}) begin
			r.result_re = w.target_re;
			r.result_im = w.target_im;
			r.action = ACT_REPLACE;
			return r;
		end
		m = root_floor(s);
		if (m == 0) m = 1;
		r.result_re = sat32(66'(w.target_re) + offset(dr, m));
		r.result_im = sat32(66'(w.target_im) + offset(di, m));
		r.action = ACT_CLAMP;
		return r;
	endfunction

	task automatic send_word(in_word_t w);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			gap = $urandom_range(0, 4);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		in_data <= w;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		expected_q.push_back(project(w));
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
		repeat (LATENCY + 5) @(negedge clk);
	endtask

	task automatic set_radius(logic [RAD_W-1:0] v);
		drain();
		wr_en <= 1'b1;
		wr_data <= v;
		@(negedge clk);
		wr_en <= 1'b0;
		radius_reg = v;
	endtask

	function automatic logic [31:0] rand_comp();
		case ($urandom_range(0, 4))
			0: return 32'h80000000;
			1: return 32'h7fffffff;
			2: return $urandom_range(0, 32'h3ffff) - 32'h20000;
			default: return $urandom;
		endcase
	endfunction

	function automatic in_word_t mk(logic [31:0] mr, logic [31:0] mi,
			logic [31:0] tr, logic [31:0] ti, logic v);
		in_word_t w;
		w.model_re = mr; w.model_im = mi;
		w.target_re = tr; w.target_im = ti; w.target_valid = v;
		return w;
	endfunction

	task automatic test_passthrough();
		send_word(mk(32'h80000000, 32'h7fffffff, 32'h1, 32'hffffffff, 1'b0));
		send_word(mk(32'h7fffffff, 32'h80000000, 32'h0, 32'h0, 1'b0));
	endtask

	task automatic test_zero_radius();
		send_word(mk(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff, 1'b1));
		send_word(mk(32'h0, 32'h0, 32'h12345678, 32'h87654321, 1'b1));
	endtask

	task automatic test_clamp_edges();
		set_radius(31'h00010000);
		send_word(mk(32'h00008000, 32'h0, 32'h0, 32'h0, 1'b1));
		send_word(mk(32'h00010000, 32'h0, 32'h0, 32'h0, 1'b1));
		send_word(mk(32'h00030000, 32'h00040000, 32'h0, 32'h0, 1'b1));
		send_word(mk(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, 1'b1));
		set_radius(31'h7fffffff);
		send_word(mk(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 1'b1));
		send_word(mk(32'h7fffffff, 32'h0, 32'h80000000, 32'h0, 1'b1));
		send_word(mk(32'h7ffffff0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b1));
		set_radius(31'd1);
		send_word(mk(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 1'b1));
		send_word(mk(32'h0, 32'h0, 32'h0, 32'h0, 1'b1));
		send_word(mk(32'h1, 32'h1, 32'h0, 32'h0, 1'b1));
	endtask

	task automatic test_random();
		logic [RAD_W-1:0] r;
		for (int phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: r = RAD_W'($urandom_range(1, 32'h40000));
				1: r = RAD_W'($urandom);
				2: r = '0;
				default: r = RAD_W'($urandom_range(1, 255));
			endcase
			set_radius(r);
			for (int i = 0; i < 100; i++)
				send_word(mk(rand_comp(), rand_comp(), rand_comp(), rand_comp(),
					$urandom_range(0, 7) != 0));
		end
	endtask

	always @(negedge clk) begin
		if (!arst_n) out_ready <= 1'b0;
		else out_ready <= ($time / 1200) % 3 == 0 ? 1'b1 : $urandom_range(0, 3) != 0;
	end

	always @(posedge clk) begin
		out_word_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				$error("result word with none expected");
				n_errors++;
			end else begin
				e = expected_q.pop_front();
				if (out_data.result_re !== e.result_re) begin
					$error("result_re exp %h got %h", e.result_re, out_data.result_re);
					n_errors++;
				end
				if (out_data.result_im !== e.result_im) begin
					$error("result_im exp %h got %h", e.result_im, out_data.result_im);
					n_errors++;
				end
				if (out_data.action !== e.action) begin
					$error("action exp %0d got %0d", e.action, out_data.action);
					n_errors++;
				end
			end
		end
	end

	initial begin
		#50_000_000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		n_errors = 0;
		burst_left = 0;
		radius_reg = '0;
		wr_en = 1'b0;
		wr_data = '0;
		in_valid = 1'b0;
		in_data = '0;
		arst_n = 1'b0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_passthrough();
		test_zero_radius();
		test_clamp_edges();
		test_random();
		drain();
		if (n_errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
